// ===== rtl/hkca_pkg.sv =====
`timescale 1ns / 1ps

package hkca_pkg;

  localparam int KEY_COUNT     = 3;
  localparam int SAMPLE_BITS   = 12;
  localparam int FULL_TRAVEL   = 400;
  localparam int EDGE_DEADZONE = 10;
  localparam int MIN_SPAN      = 100;
  localparam int SPAN_SCALE    = 400;

  localparam int SPAN_THRESHOLD = MIN_SPAN * FULL_TRAVEL / SPAN_SCALE;
  localparam int FULL_SCALE     = (1 << SAMPLE_BITS) - 1;

  localparam int KEY_BITS     = 2;
  localparam int KEY_IDX_BITS = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int DIST_BITS    = 9;
  localparam int LEVEL_BITS   = 9;
  localparam int MASK_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 9;
  localparam int NUM_BITS     = SAMPLE_BITS + DIST_BITS;
  localparam int CNT_BITS     = $clog2(DIST_BITS + 1);
  localparam int WIDE_BITS    = $clog2(FULL_SCALE + EDGE_DEADZONE + SPAN_THRESHOLD + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PRESS0   = 3'd0,
    REG_RELEASE0 = 3'd1,
    REG_PRESS1   = 3'd2,
    REG_RELEASE1 = 3'd3,
    REG_PRESS2   = 3'd4,
    REG_RELEASE2 = 3'd5,
    REG_MASK     = 3'd6,
    REG_INVERT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rest;
    logic [SAMPLE_BITS-1:0] bottom;
    logic                   calib;
    logic [DIST_BITS-1:0]   last_dist;
    logic                   down;
  } key_state_t;

  localparam key_state_t KEY_STATE_RESET = '{
    rest:      '0,
    bottom:    SAMPLE_BITS'(FULL_SCALE),
    calib:     1'b0,
    last_dist: DIST_BITS'(FULL_TRAVEL),
    down:      1'b0
  };

  typedef struct packed {
    logic                    rd_en;
    logic [KEY_IDX_BITS-1:0] rd_key;
    logic [KEY_IDX_BITS-1:0] rd_other;
    logic                    wr_en;
    logic [KEY_IDX_BITS-1:0] wr_key;
  } mem_ctrl_t;

endpackage

// ===== rtl/hkca_state_mem.sv =====
`timescale 1ns / 1ps

module hkca_state_mem
  import hkca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  mem_ctrl_t            ctrl,
  input  key_state_t           wr_data,
  output key_state_t           rd_data,
  output logic [DIST_BITS-1:0] rd_other_dist
);

  key_state_t           mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctrl.wr_en) begin
      vld[ctrl.wr_key] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_key] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data       <= vld[ctrl.rd_key] ? mem[ctrl.rd_key] : KEY_STATE_RESET;
      rd_other_dist <= vld[ctrl.rd_other] ? mem[ctrl.rd_other].last_dist
                                          : KEY_STATE_RESET.last_dist;
    end
  end

endmodule

// ===== rtl/hkca_divider.sv =====
`timescale 1ns / 1ps

module hkca_divider
  import hkca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_BITS-1:0]    numer,
  input  logic [SAMPLE_BITS-1:0] denom,
  output logic                   done,
  output logic [DIST_BITS-1:0]   quot
);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [NUM_BITS-1:0] rem;
  logic [NUM_BITS-1:0] sdiv;
  logic                ge;

  assign ge = (rem >= sdiv);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIST_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient is below 2**DIST_BITS by construction: numer < denom * 2**DIST_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      sdiv <= NUM_BITS'(denom) << (DIST_BITS - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - sdiv;
      end
      sdiv <= sdiv >> 1;
      quot <= {quot[DIST_BITS-2:0], ge};
    end
  end

endmodule

// ===== rtl/hall_key_calibrate_and_actuate_top.sv =====
`timescale 1ns / 1ps
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------------
// in       | in_valid/in_ready   | key_index, sample, filter_ready
// out      | out_valid/out_ready | out_key, travel_distance, is_pressed,
//          |                     | press_event, release_event, is_calibrated
// config   | cfg_we              | cfg_index, cfg_data
//
// One request at a time: the next accept waits for the registered result. The divide
// runs unless the distance is settled without it (uncalibrated, clamp); an unknown key
// skips to the result. The linear map's 9-step restoring divider is the longest path.
// Synchronous active-high rst clears control and the per-key valid bits; a key not yet
// written reads its reset state. A held result stalls only the write-back step.

module hall_key_calibrate_and_actuate_top
  import hkca_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KEY_BITS-1:0]      key_index,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     filter_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KEY_BITS-1:0]      out_key,
  output logic [DIST_BITS-1:0]     travel_distance,
  output logic                     is_pressed,
  output logic                     press_event,
  output logic                     release_event,
  output logic                     is_calibrated
);

  typedef enum logic [2:0] {ST_IDLE, ST_CALIB, ST_MAP, ST_DIV, ST_DONE} state_t;

  state_t state;

  logic [LEVEL_BITS-1:0] press_lvl [3];
  logic [LEVEL_BITS-1:0] rel_lvl [3];
  logic [MASK_BITS-1:0]  en_mask;
  logic                  invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_lvl <= '{default: '0};
      rel_lvl   <= '{default: LEVEL_BITS'(FULL_TRAVEL)};
      en_mask   <= '1;
      invert    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESS0:   press_lvl[0] <= cfg_data[LEVEL_BITS-1:0];
        REG_RELEASE0: rel_lvl[0]   <= cfg_data[LEVEL_BITS-1:0];
        REG_PRESS1:   press_lvl[1] <= cfg_data[LEVEL_BITS-1:0];
        REG_RELEASE1: rel_lvl[1]   <= cfg_data[LEVEL_BITS-1:0];
        REG_PRESS2:   press_lvl[2] <= cfg_data[LEVEL_BITS-1:0];
        REG_RELEASE2: rel_lvl[2]   <= cfg_data[LEVEL_BITS-1:0];
        REG_MASK:     en_mask      <= cfg_data[MASK_BITS-1:0];
        REG_INVERT:   invert       <= cfg_data[0];
        default:      invert       <= invert;
      endcase
    end
  end

  logic                   accept;
  logic                   bad_key;
  logic [KEY_BITS-1:0]    k;
  logic [SAMPLE_BITS-1:0] s;
  logic                   f_rdy;
  logic                   bad;

  logic [SAMPLE_BITS-1:0] st_rest;
  logic [SAMPLE_BITS-1:0] st_bot;
  logic                   st_calib;
  logic                   st_down;
  logic [DIST_BITS-1:0]   oth_dist;
  logic [DIST_BITS-1:0]   map_dist;

  mem_ctrl_t             mctl;
  key_state_t            wr_data;
  key_state_t            rd_data;
  logic [DIST_BITS-1:0]  rd_other_dist;

  logic                  div_start;
  logic                  div_done;
  logic [DIST_BITS-1:0]  div_quot;
  logic [NUM_BITS-1:0]   product;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !rst;
  assign bad_key = (key_index >= KEY_BITS'(KEY_COUNT));

  // calibration on the stored state
  logic [WIDE_BITS-1:0]   upper;
  logic [WIDE_BITS-1:0]   lower;
  logic                   rest_up;
  logic                   bot_down;

  always_comb begin
    upper = (s > SAMPLE_BITS'(EDGE_DEADZONE))
          ? WIDE_BITS'(s - SAMPLE_BITS'(EDGE_DEADZONE)) : '0;
    lower = WIDE_BITS'(s) + WIDE_BITS'(EDGE_DEADZONE);
    rest_up  = f_rdy && (WIDE_BITS'(rd_data.rest) < upper);
    bot_down = f_rdy && !rest_up && (WIDE_BITS'(rd_data.bottom) > lower) &&
               (WIDE_BITS'(rd_data.rest) >= lower + WIDE_BITS'(SPAN_THRESHOLD));
  end

  // linear map decisions
  logic [SAMPLE_BITS-1:0] span;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   zero_span;
  logic                   at_bottom;
  logic                   over;

  always_comb begin
    span      = st_rest - st_bot;
    diff      = s - st_bot;
    zero_span = (st_rest <= st_bot);
    at_bottom = (s <= st_bot);
    over      = (diff >= span);
    product   = NUM_BITS'(diff) * NUM_BITS'(FULL_TRAVEL);
  end

  // hysteresis
  logic                  near_pair;
  logic                  press_req;
  logic                  rel_req;
  logic                  en_bit;
  logic                  pe;
  logic                  re;
  logic                  down_next;
  logic [LEVEL_BITS-1:0] pl;
  logic [LEVEL_BITS-1:0] rl;

  always_comb begin
    near_pair = (k < KEY_BITS'(2));
    pl        = press_lvl[k];
    rl        = rel_lvl[k];
    en_bit    = en_mask[k];
    if (near_pair) begin
      press_req = (map_dist <= pl) && (map_dist < oth_dist);
      rel_req   = !press_req && ((map_dist >= rl) || (map_dist > oth_dist));
    end else begin
      press_req = (map_dist <= pl);
      rel_req   = !press_req && (map_dist >= rl);
    end
    pe        = press_req && !st_down && en_bit;
    re        = rel_req && st_down;
    down_next = (st_down || pe) && !re;
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mctl.rd_en    = accept && !bad_key;
    mctl.rd_key   = key_index[KEY_IDX_BITS-1:0];
    mctl.rd_other = KEY_IDX_BITS'(!key_index[0]);
    mctl.wr_en    = (state == ST_DONE) && out_free && !bad;
    mctl.wr_key   = k[KEY_IDX_BITS-1:0];
    wr_data       = '{rest: st_rest, bottom: st_bot, calib: st_calib,
                      last_dist: map_dist, down: down_next};
  end

  assign div_start = (state == ST_MAP) && st_calib && !zero_span && !at_bottom && !over;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            k     <= key_index;
            s     <= invert ? SAMPLE_BITS'(FULL_SCALE) - sample : sample;
            f_rdy <= filter_ready;
            bad   <= bad_key;
            state <= bad_key ? ST_DONE : ST_CALIB;
          end
        end
        ST_CALIB: begin
          st_rest  <= rest_up ? SAMPLE_BITS'(upper) : rd_data.rest;
          st_bot   <= bot_down ? SAMPLE_BITS'(lower) : rd_data.bottom;
          st_calib <= rd_data.calib || bot_down;
          st_down  <= rd_data.down;
          oth_dist <= rd_other_dist;
          state    <= ST_MAP;
        end
        ST_MAP: begin
          if (!st_calib) begin
            map_dist <= DIST_BITS'(FULL_TRAVEL);
            state    <= ST_DONE;
          end else if (zero_span) begin
            map_dist <= (s >= st_rest) ? DIST_BITS'(FULL_TRAVEL) : '0;
            state    <= ST_DONE;
          end else if (at_bottom) begin
            map_dist <= '0;
            state    <= ST_DONE;
          end else if (over) begin
            map_dist <= DIST_BITS'(FULL_TRAVEL);
            state    <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            map_dist <= div_quot;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_key         <= k;
            travel_distance <= bad ? '0 : map_dist;
            is_pressed      <= !bad && down_next;
            press_event     <= !bad && pe;
            release_event   <= !bad && re;
            is_calibrated   <= !bad && st_calib;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  hkca_state_mem u_mem (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (mctl),
    .wr_data       (wr_data),
    .rd_data       (rd_data),
    .rd_other_dist (rd_other_dist)
  );

  hkca_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (product),
    .denom (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    mctl.wr_en |=> out_valid)
    else $error("state written back without a result");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_event && release_event))
    else $error("press and release in one result");

  a_press_down: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_event |-> is_pressed)
    else $error("press event without pressed key");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hkca_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DIST_BITS-1:0] distance;
    logic                 pressed;
    logic                 press_ev;
    logic                 release_ev;
    logic                 calibrated;
  } key_report_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [KEY_BITS-1:0]      key_index;
  logic [SAMPLE_BITS-1:0]   sample;
  logic                     filter_ready;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [KEY_BITS-1:0]      out_key;
  logic [DIST_BITS-1:0]     travel_distance;
  logic                     is_pressed;
  logic                     press_event;
  logic                     release_event;
  logic                     is_calibrated;

  // mirror of the per-key calibration and switch state
  logic [SAMPLE_BITS-1:0] rest_lvl[KEY_COUNT];
  logic [SAMPLE_BITS-1:0] bottom_lvl[KEY_COUNT];
  bit                     calibrated_q[KEY_COUNT];
  logic [DIST_BITS-1:0]   prev_dist[KEY_COUNT];
  bit                     down_q[KEY_COUNT];

  logic [LEVEL_BITS-1:0]  press_lvl[3];
  logic [LEVEL_BITS-1:0]  release_lvl[3];
  logic [MASK_BITS-1:0]   enable_mask;
  bit                     invert_on;

  key_report_t pending_reports[$];
  int errors = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int stall_left = 0;

  hall_key_calibrate_and_actuate_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .key_index(key_index),
    .sample(sample),
    .filter_ready(filter_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key(out_key),
    .travel_distance(travel_distance),
    .is_pressed(is_pressed),
    .press_event(press_event),
    .release_event(release_event),
    .is_calibrated(is_calibrated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic key_report_t next_key_report(input logic [KEY_BITS-1:0] key,
                                                  input logic [SAMPLE_BITS-1:0] smp,
                                                  input logic rdy);
    key_report_t r;
    int k, s, hi, lo, rest, bot, d, other;
    bit want_press, want_release;
    r = '0;
    r.key = key;
    if (key >= KEY_COUNT) return r;
    k = key;
    s = invert_on ? FULL_SCALE - int'(smp) : int'(smp);
    if (rdy) begin
      hi = (s > EDGE_DEADZONE) ? s - EDGE_DEADZONE : 0;
      lo = s + EDGE_DEADZONE;
      if (int'(rest_lvl[k]) < hi) begin
        rest_lvl[k] = SAMPLE_BITS'(hi);
      end else if (int'(bottom_lvl[k]) > lo && int'(rest_lvl[k]) >= lo + SPAN_THRESHOLD) begin
        calibrated_q[k] = 1'b1;
        bottom_lvl[k] = SAMPLE_BITS'(lo);
      end
    end
    rest = int'(rest_lvl[k]);
    bot = int'(bottom_lvl[k]);
    if (!calibrated_q[k]) d = FULL_TRAVEL;
    else if (rest <= bot) d = (s >= rest) ? FULL_TRAVEL : 0;
    else if (s <= bot) d = 0;
    else begin
      d = (s - bot) * FULL_TRAVEL / (rest - bot);
      if (d > FULL_TRAVEL) d = FULL_TRAVEL;
    end
    prev_dist[k] = DIST_BITS'(d);
    if (k > 1) begin
      want_press = d <= int'(press_lvl[k]);
      want_release = !want_press && d >= int'(release_lvl[k]);
    end else begin
      other = int'(prev_dist[k == 0 ? 1 : 0]);
      want_press = d <= int'(press_lvl[k]) && d < other;
      want_release = !want_press && (d >= int'(release_lvl[k]) || d > other);
    end
    if (want_press && !down_q[k] && enable_mask[k]) begin
      down_q[k] = 1'b1;
      r.press_ev = 1'b1;
    end else if (want_release && down_q[k]) begin
      down_q[k] = 1'b0;
      r.release_ev = 1'b1;
    end
    r.distance = DIST_BITS'(d);
    r.pressed = down_q[k];
    r.calibrated = calibrated_q[k];
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // aim mostly inside the calibrated span and around the switch levels
  function automatic int shaped_sample(input int k);
    int lo, hi, target, s, sel;
    sel = $urandom_range(0, 99);
    if (k >= KEY_COUNT || sel < 10) return $urandom_range(0, FULL_SCALE);
    lo = int'(bottom_lvl[k]);
    hi = int'(rest_lvl[k]);
    if (sel < 45) begin
      target = $urandom_range(0, 1) ? int'(press_lvl[k]) : int'(release_lvl[k]);
      target = target + $urandom_range(0, 6) - 3;
      s = lo + target * (hi - lo) / FULL_TRAVEL;
    end else if (sel < 92) begin
      s = $urandom_range(lo > 40 ? lo - 40 : 0, hi + 40 > FULL_SCALE ? FULL_SCALE : hi + 40);
    end else begin
      s = $urandom_range(0, 1) ? FULL_SCALE : 0;
    end
    if (s < 0) s = 0;
    if (s > FULL_SCALE) s = FULL_SCALE;
    return invert_on ? FULL_SCALE - s : s;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_sample(input int key, input int smp, input logic rdy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_index <= KEY_BITS'(key);
    sample <= SAMPLE_BITS'(smp);
    filter_ready <= rdy;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(next_key_report(KEY_BITS'(key), SAMPLE_BITS'(smp), rdy));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= CFG_DATA_BITS'(v);
    case (r)
      REG_PRESS0:   press_lvl[0] = LEVEL_BITS'(v);
      REG_RELEASE0: release_lvl[0] = LEVEL_BITS'(v);
      REG_PRESS1:   press_lvl[1] = LEVEL_BITS'(v);
      REG_RELEASE1: release_lvl[1] = LEVEL_BITS'(v);
      REG_PRESS2:   press_lvl[2] = LEVEL_BITS'(v);
      REG_RELEASE2: release_lvl[2] = LEVEL_BITS'(v);
      REG_MASK:     enable_mask = MASK_BITS'(v);
      REG_INVERT:   invert_on = v[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int p0, input int r0, input int p1, input int r1,
                           input int p2, input int r2, input int mask, input int inv);
    wait_idle();
    write_reg(REG_PRESS0, p0);
    write_reg(REG_RELEASE0, r0);
    write_reg(REG_PRESS1, p1);
    write_reg(REG_RELEASE1, r1);
    write_reg(REG_PRESS2, p2);
    write_reg(REG_RELEASE2, r2);
    write_reg(REG_MASK, mask);
    write_reg(REG_INVERT, inv);
  endtask

  task automatic run_random(input int count, input int ready_pct);
    int k;
    repeat (count) begin
      k = ($urandom_range(0, 99) < 4) ? KEY_COUNT : $urandom_range(0, KEY_COUNT - 1);
      send_sample(k, shaped_sample(k), $urandom_range(0, 99) < ready_pct);
    end
  endtask

  // reset levels: press at 0, release at full travel
  task automatic test_directed();
    send_sample(KEY_COUNT, FULL_SCALE, 1'b1);
    send_sample(0, 0, 1'b0);
    send_sample(2, 2000, 1'b1);
    send_sample(2, 1950, 1'b1);
    send_sample(2, 1000, 1'b0);
    send_sample(2, 1000, 1'b1);
    send_sample(2, 3000, 1'b1);
    send_sample(2, 2000, 1'b0);
    send_sample(0, FULL_SCALE, 1'b1);
    send_sample(0, 0, 1'b1);
    send_sample(1, FULL_SCALE, 1'b1);
    send_sample(1, 0, 1'b1);
    send_sample(0, 2000, 1'b0);
    send_sample(1, 5, 1'b0);
    send_sample(1, 10, 1'b0);
    send_sample(1, 4085, 1'b0);
    send_sample(0, FULL_SCALE, 1'b0);
    send_sample(2, 2990, 1'b0);
    send_sample(2, 1010, 1'b0);
    send_sample(2, 1011, 1'b0);
    send_sample(KEY_COUNT, 0, 1'b0);
  endtask

  task automatic test_mid_levels();
    configure(150, 250, 100, 300, 200, 201, 7, 0);
    run_random(300, 30);
  endtask

  task automatic test_extreme_levels();
    configure(FULL_TRAVEL, FULL_TRAVEL, 0, 0, FULL_TRAVEL, 0, 5, 0);
    run_random(200, 30);
  endtask

  task automatic test_inverted();
    configure(120, 280, 250, 260, 50, 350, 3, 1);
    run_random(250, 30);
  endtask

  task automatic test_masked_backpressure();
    configure(200, 220, 180, 240, 100, 100, 0, 0);
    hold_requests++;
    run_random(200, 30);
  endtask

  task automatic test_no_idle();
    configure(100, 300, 100, 300, 100, 300, 7, 0);
    no_idle = 1'b1;
    run_random(200, 30);
    wait_idle();
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      stall_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : check_results
    key_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no request pending: out_key %0d", out_key);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("out_key", 16'(want.key), 16'(out_key));
        check_field("travel_distance", 16'(want.distance), 16'(travel_distance));
        check_field("is_pressed", 16'(want.pressed), 16'(is_pressed));
        check_field("press_event", 16'(want.press_ev), 16'(press_event));
        check_field("release_event", 16'(want.release_ev), 16'(release_event));
        check_field("is_calibrated", 16'(want.calibrated), 16'(is_calibrated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL hall_key_calibrate_and_actuate_top");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    key_index <= '0;
    sample <= '0;
    filter_ready <= 1'b0;
    for (int k = 0; k < 3; k++) begin
      press_lvl[k] = '0;
      release_lvl[k] = LEVEL_BITS'(FULL_TRAVEL);
    end
    enable_mask = '1;
    invert_on = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      rest_lvl[k] = '0;
      bottom_lvl[k] = SAMPLE_BITS'(FULL_SCALE);
      calibrated_q[k] = 1'b0;
      prev_dist[k] = DIST_BITS'(FULL_TRAVEL);
      down_q[k] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_mid_levels();
    test_extreme_levels();
    test_inverted();
    test_masked_backpressure();
    test_no_idle();
    wait_idle();
    if (errors == 0) begin
      $display("PASS hall_key_calibrate_and_actuate_top");
    end else begin
      $display("FAIL hall_key_calibrate_and_actuate_top");
    end
    $finish;
  end

endmodule
